// ===== sv/crc24_color_hash_unit_assert.svh =====
// Assertion macros used by the top-level RTL file. Each property is checked on the
// rising edge of clk and is disabled while rst_n is low.
`ifndef CRC24_COLOR_HASH_UNIT_ASSERT_SVH
`define CRC24_COLOR_HASH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CCH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property failed");
`define CCH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property failed");
`else
`define CCH_ASSERT_SAME(label, ante, cons)
`define CCH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/cch_pkg.sv =====
package cch_pkg;

  localparam int CRC_W       = 24;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int OUT_W       = 3 * CRC_W;

  localparam logic [CRC_W-1:0] CRC_INITIAL_RESET    = 24'hB704CE;
  localparam logic [CRC_W-1:0] CRC_POLYNOMIAL_RESET = 24'h864CFB;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CRC_INITIAL    = 1'b0,
    CFG_CRC_POLYNOMIAL = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic               we;
    cfg_index_t         index;
    logic [CRC_W-1:0]   wdata;
  } cfg_write_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
  } cch_item_t;

  typedef struct packed {
    logic [CRC_W-1:0] shade_color;
    logic [CRC_W-1:0] tint_color;
    logic [CRC_W-1:0] crc_value;
  } cch_result_t;

  // Folds one byte into the CRC, MSB first, eight shift/XOR steps.
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0]  crc,
                                                input logic [BYTE_W-1:0] data,
                                                input logic [CRC_W-1:0]  poly);
    logic [CRC_W-1:0] c;
    logic             msb;
    c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      msb = c[CRC_W-1];
      c   = {c[CRC_W-2:0], 1'b0};
      if (msb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

  // Moves a channel halfway toward full scale; the sum never exceeds 255.
  function automatic logic [7:0] tint_channel(input logic [7:0] c);
    logic [7:0] gap;
    gap = 8'hFF - c;
    return c + (gap >> 1);
  endfunction

  function automatic logic [7:0] shade_channel(input logic [7:0] c);
    return c >> 2;
  endfunction

endpackage

// ===== sv/cch_crc_core.sv =====
module cch_crc_core
  import cch_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_write_t        cfg,
  input  logic              step,
  input  cch_item_t         item,
  output logic [CRC_W-1:0]  crc_cur
);

  logic [CRC_W-1:0] crc_initial_r;
  logic [CRC_W-1:0] crc_polynomial_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_initial_r    <= CRC_INITIAL_RESET;
      crc_polynomial_r <= CRC_POLYNOMIAL_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_CRC_INITIAL:    crc_initial_r    <= cfg.wdata;
        CFG_CRC_POLYNOMIAL: crc_polynomial_r <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // A terminator reloads the initial value; the old CRC has already been
  // captured by the result stage in the same cycle.
  always_comb begin
    crc_nxt = crc_r;
    if (step) begin
      if (item.end_of_string) begin
        crc_nxt = crc_initial_r;
      end else begin
        crc_nxt = crc_fold(crc_r, item.data_byte, crc_polynomial_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INITIAL_RESET;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc_cur = crc_r;

endmodule

// ===== sv/cch_result_stage.sv =====
module cch_result_stage
  import cch_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [CRC_W-1:0]  crc,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata
);

  logic        valid_r;
  logic        valid_nxt;
  cch_result_t result_r;
  cch_result_t result_nxt;

  assign free = !valid_r || out_tready;

  always_comb begin
    result_nxt.crc_value   = crc;
    result_nxt.tint_color  = {tint_channel(crc[23:16]), tint_channel(crc[15:8]),
                              tint_channel(crc[7:0])};
    result_nxt.shade_color = {shade_channel(crc[23:16]), shade_channel(crc[15:8]),
                              shade_channel(crc[7:0])};
    valid_nxt = load || (valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = result_r;

endmodule

// ===== sv/crc24_color_hash_unit.sv =====
// Channel  Dir  Ports                            Contents
// in       in   in_tvalid/tready/tdata/tlast     one string byte, tlast = terminator
// out      out  out_tvalid/tready/tdata          CRC and two RGB888 colors
// cfg      in   cfg_we/cfg_index/cfg_wdata       0 initial CRC, 1 polynomial
//
// One request per clock while no terminator waits in the input register: a byte
// is registered, then folded into the running CRC by eight unrolled shift/XOR
// steps in the next cycle; a terminator moves on once the output register is free.
// Reset (rst_n low, synchronous) loads the register reset values and the CRC.
// A byte in the input register always moves on; a terminator waits there while
// the output register is full, and new requests are held off meanwhile.
module crc24_color_hash_unit
  import cch_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [BYTE_W-1:0]       in_tdata,   // [7:0] data_byte
  input  logic                    in_tlast,   // end_of_string
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_W-1:0]        out_tdata,  // [23:0] crc_value, [47:24] tint_color,
                                              // [71:48] shade_color
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CRC_W-1:0]        cfg_wdata
);

`include "crc24_color_hash_unit_assert.svh"

  logic             s1_valid_r;
  cch_item_t        s1_item_r;
  logic             s1_adv;
  logic             out_free;
  logic [CRC_W-1:0] crc_cur;
  cfg_write_t       cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index_t'(cfg_index);
  assign cfg.wdata = cfg_wdata;

  assign s1_adv    = s1_valid_r && (!s1_item_r.end_of_string || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.data_byte     <= in_tdata;
      s1_item_r.end_of_string <= in_tlast;
    end
  end

  cch_crc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (s1_adv),
    .item    (s1_item_r),
    .crc_cur (crc_cur)
  );

  cch_result_stage u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv && s1_item_r.end_of_string),
    .crc        (crc_cur),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `CCH_ASSERT_SAME(a_byte_never_stalls, s1_valid_r && !s1_item_r.end_of_string, s1_adv)
  `CCH_ASSERT_SAME(a_blocked_result_holds_input,
                   s1_valid_r && s1_item_r.end_of_string && out_tvalid && !out_tready,
                   !in_tready)
  `CCH_ASSERT_NEXT(a_result_carries_crc, s1_adv && s1_item_r.end_of_string,
                   out_tvalid && (out_tdata[CRC_W-1:0] == $past(crc_cur)))

endmodule
